// ----- sv/plt_pkg.sv -----
// Package: list depth, operation and status codes, cell command type.
`timescale 1ns / 1ps
package plt_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = 5;
  localparam int POS_W = 5;
  localparam int DATA_W = 32;
  localparam int CAP_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_t;

  localparam logic [0:0] REG_CAPACITY_LIMIT = 1'd0;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] sel;
    data_t            value;
  } cell_cmd_t;

endpackage

// ----- sv/plt_if.sv -----
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface plt_req_if;
  import plt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [POS_W-1:0]        position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface plt_rsp_if;
  import plt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [DATA_W-1:0] read_value;
  logic [LEN_W-1:0]        found_position;
  logic [LEN_W-1:0]        list_length;

  modport source (output valid, output status, output read_value,
                  output found_position, output list_length, input ready);
  modport sink (input valid, input status, input read_value,
                input found_position, input list_length, output ready);
endinterface

// ----- sv/plt_cell.sv -----
// One list entry cell: load, shift up from the left, shift down from the right, compare.
`timescale 1ns / 1ps
module plt_cell
  import plt_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_index,
  input  cell_cmd_t        cmd,
  input  data_t            left_data,
  input  data_t            right_data,
  output data_t            data,
  output logic             match
);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (cell_index == cmd.sel) begin
        data <= cmd.value;
      end else if (cell_index > cmd.sel) begin
        data <= left_data;
      end
    end else if (cmd.del) begin
      if (cell_index >= cmd.sel) begin
        data <= right_data;
      end
    end
  end

  assign match = (data == cmd.value);

endmodule

// ----- sv/plt_chain.sv -----
// Row of entry cells with the read select and the first-match encoder.
`timescale 1ns / 1ps
module plt_chain
  import plt_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [LEN_W-1:0] used_count,
  output data_t            rd_data,
  output logic [LEN_W-1:0] found
);

  data_t      cell_data [DEPTH];
  logic [DEPTH-1:0] match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_d;
    data_t right_d;
    if (i == 0) begin : g_first
      assign left_d = cmd.value;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    plt_cell u_cell (
      .clk        (clk),
      .cell_index (IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (match[i])
    );
  end

  assign rd_data = cell_data[cmd.sel];

  always_comb begin
    found = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i] && (LEN_W'(i) < used_count)) begin
        found = LEN_W'(i + 1);
      end
    end
  end

endmodule

// ----- sv/positional_list_table.sv -----
// Top level: ordered list of signed words with insert, delete, get and locate.
//
// Requests arrive on req (operation, position, value) and are taken when
// req.valid and req.ready are both high. Each request yields one response on
// rsp (status, read_value, found_position, list_length), registered and shown
// in the cycle after the request is taken. For each request the row of
// entry cells shifts, loads or compares all entries in the same edge, and the
// output register frees the request side as soon as the response is taken.
// Throughput is one request per cycle while rsp.ready is high; when the
// receiver stalls, the pending response holds and req.ready drops until it
// is taken.
// Positions are one-based. The list reports full once its length reaches
// min(capacity_limit, DEPTH). capacity_limit sits at APB byte address 0; the
// user must write it only while no request is in flight; the block won't check.
// Reset (rst, synchronous) empties the list, drops any pending response and
// sets capacity_limit to 3; entry contents are not cleared.
`timescale 1ns / 1ps
module positional_list_table
  import plt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  plt_req_if.sink     req,
  plt_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CAP_W-1:0] capacity_limit;
  logic [LEN_W-1:0] used_count;
  logic [LEN_W-1:0] used_count_next;
  logic             out_valid;
  logic             take;
  cell_cmd_t        cmd;
  data_t            rd_data;
  logic [LEN_W-1:0] found;
  logic [LEN_W:0]   eff_cap;
  logic             pos_nonzero;
  logic             pos_in_list;
  logic             pos_ins_ok;
  logic             full;
  logic [IDX_W-1:0] pos_m1;
  status_t          status_next;
  data_t            read_next;
  logic [LEN_W-1:0] found_next;
  op_t              op;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == REG_CAPACITY_LIMIT)
                  ? {{(32-CAP_W){1'b0}}, capacity_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_W'(3);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[1] == REG_CAPACITY_LIMIT)) begin
      capacity_limit <= pwdata[CAP_W-1:0];
    end
  end

  assign req.ready = !out_valid || rsp.ready;
  assign take = req.valid && req.ready;
  assign op = op_t'(req.operation);

  assign eff_cap = ((LEN_W+1)'(capacity_limit) < (LEN_W+1)'(DEPTH))
                   ? (LEN_W+1)'(capacity_limit) : (LEN_W+1)'(DEPTH);
  assign full = (LEN_W+1)'(used_count) >= eff_cap;
  assign pos_nonzero = (req.position != '0);
  assign pos_in_list = pos_nonzero &&
                       ((LEN_W+1)'(req.position) <= (LEN_W+1)'(used_count));
  assign pos_ins_ok = pos_nonzero &&
                      ((LEN_W+1)'(req.position) <= (LEN_W+1)'(used_count) + 1'b1);
  assign pos_m1 = IDX_W'(req.position - 1'b1);

  always_comb begin
    cmd.ins = 1'b0;
    cmd.del = 1'b0;
    cmd.sel = pos_m1;
    cmd.value = req.value;
    status_next = ST_OK;
    read_next = '0;
    found_next = '0;
    used_count_next = used_count;
    case (op)
      OP_INSERT: begin
        if (!pos_ins_ok) begin
          status_next = ST_BAD_POS;
        end else if (full) begin
          status_next = ST_LIST_FULL;
        end else begin
          cmd.ins = take;
          used_count_next = used_count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!pos_in_list) begin
          status_next = ST_BAD_POS;
        end else begin
          cmd.del = take;
          used_count_next = used_count - 1'b1;
        end
      end
      OP_GET: begin
        if (!pos_in_list) begin
          status_next = ST_BAD_POS;
        end else begin
          read_next = rd_data;
        end
      end
      OP_LOCATE: begin
        found_next = found;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  plt_chain u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .used_count (used_count),
    .rd_data    (rd_data),
    .found      (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      used_count <= used_count_next;
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.status <= status_next;
      rsp.read_value <= read_next;
      rsp.found_position <= found_next;
      rsp.list_length <= used_count_next;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ----- dv/positional_list_table_test.sv -----
// Testbench for positional_list_table: random and directed list requests checked against a model.
`timescale 1ns / 1ps
module positional_list_table_test;
  import plt_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    op_t              op;
    logic [POS_W-1:0] pos;
    data_t            val;
  } list_request_t;

  typedef struct {
    status_t          status;
    data_t            read_value;
    logic [LEN_W-1:0] found_position;
    logic [LEN_W-1:0] list_length;
  } list_response_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  plt_req_if req_ch ();
  plt_rsp_if rsp_ch ();

  positional_list_table u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  data_t            list_words [DEPTH];
  int               list_len;
  logic [CAP_W-1:0] capacity_setting;

  list_request_t  pending_requests [$];
  list_response_t expected_responses [$];
  data_t          value_pool [8];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  req_fired = 1'b0;
  bit  rsp_fired = 1'b0;
  int  send_gap = 0;
  int  send_calm = 0;
  int  recv_hold = 0;
  int  recv_calm = 0;
  int  send_draw;
  int  recv_draw;
  list_request_t next_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic draw_gap(inout int calm, output int len);
    int r;
    r = $urandom_range(99);
    if (calm > 0) begin
      calm--;
      len = 0;
    end else if (r < 2) begin
      calm = $urandom_range(20, 60);
      len = 0;
    end else if (r < 65) begin
      len = 0;
    end else if (r < 95) begin
      len = $urandom_range(1, 3);
    end else begin
      len = $urandom_range(8, 40);
    end
  endtask

  task automatic apply_request(input list_request_t rq, output list_response_t rs);
    int pos;
    int room;
    rs.status = ST_OK;
    rs.read_value = '0;
    rs.found_position = '0;
    pos = rq.pos;
    room = (capacity_setting < DEPTH) ? capacity_setting : DEPTH;
    case (rq.op)
      OP_INSERT: begin
        if (pos < 1 || pos > list_len + 1) begin
          rs.status = ST_BAD_POS;
        end else if (list_len >= room) begin
          rs.status = ST_LIST_FULL;
        end else begin
          for (int j = list_len; j >= pos; j--) list_words[j] = list_words[j-1];
          list_words[pos-1] = rq.val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          rs.status = ST_BAD_POS;
        end else begin
          for (int j = pos; j < list_len; j++) list_words[j-1] = list_words[j];
          list_len--;
        end
      end
      OP_GET: begin
        if (pos < 1 || pos > list_len) rs.status = ST_BAD_POS;
        else rs.read_value = list_words[pos-1];
      end
      default: begin
        for (int j = list_len - 1; j >= 0; j--) begin
          if (list_words[j] == rq.val) rs.found_position = LEN_W'(j + 1);
        end
      end
    endcase
    rs.list_length = LEN_W'(list_len);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        req_ch.operation <= next_req.op;
        req_ch.position <= next_req.pos;
        req_ch.value <= next_req.val;
        req_ch.valid <= 1'b1;
        draw_gap(send_calm, send_draw);
        send_gap = send_draw;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response ready
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_fired) begin
      draw_gap(recv_calm, recv_draw);
      if (recv_draw > 0) begin
        recv_hold = recv_draw - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    list_request_t  rq;
    list_response_t rs;
    list_response_t want;
    cycle_count <= cycle_count + 1;
    req_fired <= !rst && req_ch.valid && req_ch.ready;
    rsp_fired <= !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        rq.op = op_t'(req_ch.operation);
        rq.pos = req_ch.position;
        rq.val = req_ch.value;
        apply_request(rq, rs);
        expected_responses.push_back(rs);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("response with no request waiting");
        end else begin
          want = expected_responses.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d exp %0d", rsp_ch.status, want.status));
          if (rsp_ch.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d exp %0d",
                                      rsp_ch.read_value, want.read_value));
          if (rsp_ch.found_position !== want.found_position)
            report_mismatch($sformatf("found_position got %0d exp %0d",
                                      rsp_ch.found_position, want.found_position));
          if (rsp_ch.list_length !== want.list_length)
            report_mismatch($sformatf("list_length got %0d exp %0d",
                                      rsp_ch.list_length, want.list_length));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic check_capacity_readback();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 2'(4 * REG_CAPACITY_LIMIT);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (pready !== 1'b1)
      report_mismatch("pready low during register access");
    if (prdata !== 32'(capacity_setting))
      report_mismatch($sformatf("capacity_limit read %0d exp %0d", prdata, capacity_setting));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_capacity(input int cap);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 2'(4 * REG_CAPACITY_LIMIT);
    pwdata = 32'(cap);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    capacity_setting = CAP_W'(cap);
    check_capacity_readback();
  endtask

  task automatic push_request(input op_t op, input int pos, input data_t val);
    list_request_t rq;
    rq.op = op;
    rq.pos = POS_W'(pos);
    rq.val = val;
    pending_requests.push_back(rq);
  endtask

  task automatic push_random_requests(input int count, input int ins_w, input int del_w);
    int    r;
    int    room;
    int    pos;
    op_t   op;
    data_t val;
    room = (capacity_setting < DEPTH) ? capacity_setting : DEPTH;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < ins_w) op = OP_INSERT;
      else if (r < ins_w + del_w) op = OP_DELETE;
      else if (r < ins_w + del_w + (100 - ins_w - del_w) / 2) op = OP_GET;
      else op = OP_LOCATE;
      if ($urandom_range(99) < 85) pos = $urandom_range(1, room + 1);
      else pos = $urandom_range(0, 31);
      r = $urandom_range(99);
      if (r < 50) val = value_pool[$urandom_range(7)];
      else val = $urandom;
      push_request(op, pos, val);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int caps [8];
    int ins_ws [8];
    int del_ws [8];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_INSERT;
    req_ch.position = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    list_len = 0;
    capacity_setting = CAP_W'(3);
    for (int i = 0; i < DEPTH; i++) list_words[i] = '0;
    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    caps = '{16, 0, 31, 1, 5, 2, 16, 8};
    ins_ws = '{55, 30, 45, 40, 40, 35, 20, 40};
    del_ws = '{10, 30, 20, 25, 25, 30, 45, 25};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_capacity_readback();

    push_request(OP_GET, 1, 32'sd0);
    push_request(OP_DELETE, 1, 32'sd0);
    push_request(OP_DELETE, 0, 32'sd0);
    push_request(OP_INSERT, 0, 32'sd5);
    push_request(OP_INSERT, 2, 32'sd5);
    push_request(OP_LOCATE, 0, 32'sd0);
    push_request(OP_INSERT, 1, 32'sh7fffffff);
    push_request(OP_INSERT, 1, 32'sh80000000);
    push_request(OP_INSERT, 3, -32'sd1);
    push_request(OP_INSERT, 1, 32'sh12345678);
    push_request(OP_INSERT, 31, 32'sh12345678);
    push_request(OP_LOCATE, 0, -32'sd1);
    push_request(OP_LOCATE, 0, 32'sh7fffffff);
    push_request(OP_LOCATE, 31, 32'sd0);
    push_request(OP_GET, 1, 32'sd0);
    push_request(OP_GET, 3, 32'sd0);
    push_request(OP_GET, 4, 32'sd0);
    push_request(OP_GET, 31, 32'sd0);
    push_request(OP_DELETE, 2, 32'sd0);
    push_request(OP_GET, 2, 32'sd0);
    push_request(OP_DELETE, 3, 32'sd0);
    push_request(OP_DELETE, 2, 32'sd0);
    push_request(OP_INSERT, 1, 32'sd0);
    push_request(OP_LOCATE, 0, 32'sd0);
    push_request(OP_GET, 2, 32'sd0);
    push_random_requests(140, 40, 25);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      push_random_requests(160, ins_ws[p], del_ws[p]);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/plt_pkg.sv
sv/plt_if.sv
sv/plt_cell.sv
sv/plt_chain.sv
sv/positional_list_table.sv
dv/positional_list_table_test.sv
